// File: sv/bpq_pkg.sv
// Package for the bounded priority queue with drop-lowest on overflow.
// Holds the sizes, the status and opcode codes, and the request, result and level-selection types.
// No dependencies.
package bpq_pkg;

	localparam int DEPTH   = 16;
	localparam int LEVELS  = 10;
	localparam int DATA_W  = 32;
	localparam int PRIO_W  = 4;
	localparam int COUNT_W = 5;
	localparam int SLOT_W  = $clog2(DEPTH);
	localparam int LVL_W   = $clog2(LEVELS);
	localparam int CNT_W   = $clog2(DEPTH + 1);

	typedef enum logic [0:0] {
		OP_PUSH = 1'b0,
		OP_PULL = 1'b1
	} bpq_op_t;

	typedef enum logic [2:0] {
		ST_PUSHED  = 3'd0,
		ST_DROPPED = 3'd1,
		ST_FULL    = 3'd2,
		ST_PULLED  = 3'd3,
		ST_EMPTY   = 3'd4
	} bpq_status_t;

	typedef struct packed {
		logic [0:0]        opcode;
		logic [PRIO_W-1:0] priority_req;
		logic [DATA_W-1:0] message_data;
	} bpq_req_t;

	typedef struct packed {
		logic [2:0]         status;
		logic [DATA_W-1:0]  result_data;
		logic [PRIO_W-1:0]  dropped_level;
		logic [COUNT_W-1:0] waiting_count;
	} bpq_res_t;

	typedef struct packed {
		logic             drop_found;
		logic [LVL_W-1:0] drop_lv;
		logic             pull_found;
		logic [LVL_W-1:0] pull_lv;
	} bpq_sel_t;

endpackage

// File: sv/bpq_ram.sv
// Generic single-write, single-read RAM with a registered, read-first output.
// No dependencies.
module bpq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	assign rdata = rdata_q;

endmodule

// File: sv/bpq_prio_enc.sv
// Level selection: lowest non-empty level below the push priority, and
// highest non-empty level for a pull. Uses bpq_pkg.
module bpq_prio_enc (
	input  logic [bpq_pkg::LEVELS-1:0] nonempty,
	input  logic [bpq_pkg::LVL_W-1:0]  prio,
	output bpq_pkg::bpq_sel_t          sel
);

	logic [bpq_pkg::LEVELS-1:0] below;

	always_comb begin
		sel = '0;
		for (int i = 0; i < bpq_pkg::LEVELS; i++) begin
			below[i] = nonempty[i] && (bpq_pkg::LVL_W'(i) < prio);
		end
		for (int i = bpq_pkg::LEVELS - 1; i >= 0; i--) begin
			if (below[i]) begin
				sel.drop_found = 1'b1;
				sel.drop_lv    = bpq_pkg::LVL_W'(i);
			end
		end
		for (int i = 0; i < bpq_pkg::LEVELS; i++) begin
			if (nonempty[i]) begin
				sel.pull_found = 1'b1;
				sel.pull_lv    = bpq_pkg::LVL_W'(i);
			end
		end
	end

endmodule

// File: sv/bpq_engine.sv
// Queue state, link updates and result register of the priority queue.
// Uses bpq_pkg, bpq_prio_enc and bpq_ram.
module bpq_engine (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fire,
	input  bpq_pkg::bpq_req_t req_s1,
	output bpq_pkg::bpq_res_t res
);

	localparam int SW = bpq_pkg::SLOT_W;
	localparam int LW = bpq_pkg::LVL_W;
	localparam int CW = bpq_pkg::CNT_W;
	localparam int NL = bpq_pkg::LEVELS;
	localparam int ND = bpq_pkg::DEPTH;

	logic [SW-1:0] next_q [ND];
	logic [SW-1:0] prev_q [ND];
	logic [SW-1:0] head_q [NL];
	logic [SW-1:0] tail_q [NL];
	logic [SW-1:0] head_d [NL];
	logic [SW-1:0] tail_d [NL];
	logic [NL-1:0] nonempty_q, nonempty_d;
	logic [SW-1:0] free_top_q, free_top_d;
	logic [CW-1:0] free_cnt_q, free_cnt_d;
	logic [CW-1:0] queued_q, queued_d;

	logic [2:0]    status_q;
	logic [LW-1:0] level_q;
	logic          use_ram_q;

	logic [LW-1:0] prio;
	logic          is_pull, has_free;
	logic          do_push, do_drop, do_pull;
	logic [SW-1:0] drop_slot, pull_slot, app_slot;
	logic          nxt_we, prv_we;
	logic [SW-1:0] nxt_addr, nxt_data, prv_addr, prv_data;
	logic [2:0]    status_d;
	logic [bpq_pkg::DATA_W-1:0] ram_rdata;
	bpq_pkg::bpq_sel_t sel;

	assign prio = (req_s1.priority_req >= bpq_pkg::PRIO_W'(NL)) ? LW'(NL - 1)
		: LW'(req_s1.priority_req);

	bpq_prio_enc u_enc (
		.nonempty (nonempty_q),
		.prio     (prio),
		.sel      (sel)
	);

	assign is_pull   = (req_s1.opcode == bpq_pkg::OP_PULL);
	assign has_free  = (free_cnt_q != '0);
	assign do_push   = fire && !is_pull && has_free;
	assign do_drop   = fire && !is_pull && !has_free && sel.drop_found;
	assign do_pull   = fire && is_pull && sel.pull_found;
	assign drop_slot = tail_q[sel.drop_lv];
	assign pull_slot = head_q[sel.pull_lv];
	assign app_slot  = do_push ? free_top_q : drop_slot;

	always_comb begin
		head_d     = head_q;
		tail_d     = tail_q;
		nonempty_d = nonempty_q;
		free_top_d = free_top_q;
		free_cnt_d = free_cnt_q;
		queued_d   = queued_q;
		nxt_we     = 1'b0;
		nxt_addr   = pull_slot;
		nxt_data   = free_top_q;
		prv_we     = 1'b0;
		prv_addr   = app_slot;
		prv_data   = tail_q[prio];
		if (do_drop) begin
			if (head_q[sel.drop_lv] == drop_slot) begin
				nonempty_d[sel.drop_lv] = 1'b0;
			end else begin
				tail_d[sel.drop_lv] = prev_q[drop_slot];
			end
		end
		if (do_pull) begin
			if (tail_q[sel.pull_lv] == pull_slot) begin
				nonempty_d[sel.pull_lv] = 1'b0;
			end else begin
				head_d[sel.pull_lv] = next_q[pull_slot];
			end
			nxt_we     = 1'b1;
			free_top_d = pull_slot;
			free_cnt_d = free_cnt_q + CW'(1);
			queued_d   = queued_q - CW'(1);
		end
		if (do_push) begin
			free_top_d = next_q[free_top_q];
			free_cnt_d = free_cnt_q - CW'(1);
			queued_d   = queued_q + CW'(1);
		end
		if (do_push || do_drop) begin
			if (!nonempty_q[prio]) begin
				head_d[prio]     = app_slot;
				tail_d[prio]     = app_slot;
				nonempty_d[prio] = 1'b1;
			end else begin
				nxt_we       = 1'b1;
				nxt_addr     = tail_q[prio];
				nxt_data     = app_slot;
				prv_we       = 1'b1;
				tail_d[prio] = app_slot;
			end
		end
	end

	always_comb begin
		if (is_pull) begin
			status_d = sel.pull_found ? bpq_pkg::ST_PULLED : bpq_pkg::ST_EMPTY;
		end else if (has_free) begin
			status_d = bpq_pkg::ST_PUSHED;
		end else begin
			status_d = sel.drop_found ? bpq_pkg::ST_DROPPED : bpq_pkg::ST_FULL;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ND; i++) begin
				next_q[i] <= (i == ND - 1) ? '0 : SW'(i + 1);
			end
			for (int i = 0; i < NL; i++) begin
				head_q[i] <= '0;
				tail_q[i] <= '0;
			end
			nonempty_q <= '0;
			free_top_q <= '0;
			free_cnt_q <= CW'(ND);
			queued_q   <= '0;
			status_q   <= bpq_pkg::ST_PUSHED;
			level_q    <= '0;
			use_ram_q  <= 1'b0;
		end else if (fire) begin
			if (nxt_we) begin
				next_q[nxt_addr] <= nxt_data;
			end
			head_q     <= head_d;
			tail_q     <= tail_d;
			nonempty_q <= nonempty_d;
			free_top_q <= free_top_d;
			free_cnt_q <= free_cnt_d;
			queued_q   <= queued_d;
			status_q   <= status_d;
			level_q    <= do_drop ? sel.drop_lv : '0;
			use_ram_q  <= do_drop || do_pull;
		end
	end

	always_ff @(posedge clk) begin
		if (prv_we) begin
			prev_q[prv_addr] <= prv_data;
		end
	end

	bpq_ram #(
		.WIDTH (bpq_pkg::DATA_W),
		.DEPTH (ND)
	) u_payload (
		.clk   (clk),
		.we    (do_push || do_drop),
		.waddr (app_slot),
		.wdata (req_s1.message_data),
		.re    (do_drop || do_pull),
		.raddr (do_pull ? pull_slot : drop_slot),
		.rdata (ram_rdata)
	);

	assign res.status        = status_q;
	assign res.result_data   = use_ram_q ? ram_rdata : '0;
	assign res.dropped_level = bpq_pkg::PRIO_W'(level_q);
	assign res.waiting_count = bpq_pkg::COUNT_W'(queued_q);

`ifndef NO_ASSERTIONS
	a_count_sum: assert property (@(posedge clk) disable iff (!arst_n)
		(CW'(1) + free_cnt_q + queued_q) == CW'(ND + 1))
		else $error("free and queued counts do not add up to the slot count");

	a_nonempty_count: assert property (@(posedge clk) disable iff (!arst_n)
		(nonempty_q == '0) == (queued_q == '0))
		else $error("level mask disagrees with the queued count");

	a_pull_taken: assert property (@(posedge clk) disable iff (!arst_n)
		fire && is_pull && (nonempty_q != '0) |=> status_q == bpq_pkg::ST_PULLED)
		else $error("pull with queued messages did not return one");

	a_drop_keeps_count: assert property (@(posedge clk) disable iff (!arst_n)
		do_drop |=> queued_q == CW'(ND))
		else $error("drop changed the queued count");
`endif

endmodule

// File: sv/bounded_priority_queue_drop_lowest_core.sv
// Top level of the bounded priority queue with drop-lowest on overflow.
// Input register and result handshake; uses bpq_pkg and bpq_engine.
//
//   channel  | valid     | stall     | payload
//   request  | req_valid | req_stall | req_data (bpq_req_t)
//   result   | res_valid | res_stall | res_data (bpq_res_t)
//
// One request is accepted every cycle while the result side keeps up.
// A request is held in the input register until it fires, and its result is then
// registered in the engine; the link update and level encode lie between the two.
// Reset clears all queues and the free chain at once, with no sweep.
// A stalled result holds the input register, which then stalls requests.
module bounded_priority_queue_drop_lowest_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  bpq_pkg::bpq_req_t req_data,
	output logic              res_valid,
	input  logic              res_stall,
	output bpq_pkg::bpq_res_t res_data
);

	logic              s1_valid_q;
	bpq_pkg::bpq_req_t req_s1;
	logic              res_valid_q;
	logic              advance;
	logic              fire;

	assign advance   = !res_valid_q || !res_stall;
	assign fire      = s1_valid_q && advance;
	assign req_stall = s1_valid_q && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (!req_stall) begin
				s1_valid_q <= req_valid;
			end
			if (advance) begin
				res_valid_q <= s1_valid_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!req_stall && req_valid) begin
			req_s1 <= req_data;
		end
	end

	bpq_engine u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.req_s1 (req_s1),
		.res    (res_data)
	);

	assign res_valid = res_valid_q;

endmodule
